// ===== hdl/aapr_pkg.sv =====
// Shared widths, types, register indexes and rounding helpers for the axis-angle point rotator.
package aapr_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int COEF_WIDTH  = 16;
   localparam int FRAC        = COEF_WIDTH - 2;

   localparam int CSR_WIDTH   = (COORD_WIDTH > COEF_WIDTH) ? COORD_WIDTH : COEF_WIDTH;
   localparam int CSR_INDEX_W = 3;
   localparam int TDATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8;

   // coefficient growth: 1-c, rounded coef products, scaled products, matrix entries
   localparam int OMC_W = COEF_WIDTH + 1;
   localparam int EE_W  = COEF_WIDTH + 2;
   localparam int K_W   = COEF_WIDTH + 3;
   localparam int MAT_W = COEF_WIDTH + 4;

   // point datapath growth
   localparam int D_W    = COORD_WIDTH + 1;
   localparam int PROD_W = MAT_W + D_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int SH_W   = ACC_W - FRAC;
   localparam int SUM_W  = SH_W + 1;

   localparam int HALF = 1 << (FRAC - 1);

   // matrix derivation depth; the input is held off after a write until the matrix has settled
   localparam int MAT_STAGES    = 3;
   localparam int SETTLE_CYCLES = MAT_STAGES - 1;
   localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [MAT_W-1:0]       mat_entry_type;
   typedef mat_entry_type [8:0]           mat_type;

   localparam coef_type COEF_ONE = coef_type'(1) << FRAC;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_AXIS_X   = 3'd0,
      REG_AXIS_Y   = 3'd1,
      REG_AXIS_Z   = 3'd2,
      REG_COS      = 3'd3,
      REG_SIN      = 3'd4,
      REG_ORIGIN_X = 3'd5,
      REG_ORIGIN_Y = 3'd6,
      REG_ORIGIN_Z = 3'd7
   } reg_index_type;

   // settings seen by the point datapath
   typedef struct packed {
      mat_type          mat;
      coord_type [2:0]  origin;
      logic             settled;
   } cfg_type;

   // round(a*b) at FRAC fractional bits, ties toward +inf
   function automatic logic signed [EE_W-1:0] coef_rnd_mul(input coef_type a,
                                                          input coef_type b);
      logic signed [2*COEF_WIDTH:0] p;
      p = a * b;
      p = p + (2*COEF_WIDTH+1)'(HALF);
      return EE_W'(p >>> FRAC);
   endfunction

   function automatic logic signed [K_W-1:0] k_rnd_mul(input logic signed [OMC_W-1:0] a,
                                                      input logic signed [EE_W-1:0] b);
      logic signed [OMC_W+EE_W:0] p;
      p = a * b;
      p = p + (OMC_W+EE_W+1)'(HALF);
      return K_W'(p >>> FRAC);
   endfunction

endpackage

// ===== hdl/aapr_cfg.sv =====
// Settings registers and the three-stage pipeline that forms the rotation matrix.
module aapr_cfg
   import aapr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_WIDTH-1:0]   wr_data,
   output cfg_type                cfg
);

   coef_type  axis_x_ff, axis_y_ff, axis_z_ff, cos_ff, sin_ff;
   coef_type  axis_x_in, axis_y_in, axis_z_in, cos_in, sin_in;
   coord_type [2:0] origin_ff, origin_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;

   // stage 1: rounded coefficient products
   logic signed [EE_W-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [EE_W-1:0] xs1_ff, ys1_ff, zs1_ff;
   logic signed [EE_W-1:0] xx_in, yy_in, zz_in, xy_in, xz_in, yz_in;
   logic signed [EE_W-1:0] xs1_in, ys1_in, zs1_in;
   logic signed [OMC_W-1:0] omc_ff, omc_in;
   coef_type  c1_ff, c1_in;

   // stage 2: (1-c) scaled terms
   logic signed [K_W-1:0] kxx_ff, kyy_ff, kzz_ff, kxy_ff, kxz_ff, kyz_ff;
   logic signed [K_W-1:0] kxx_in, kyy_in, kzz_in, kxy_in, kxz_in, kyz_in;
   logic signed [EE_W-1:0] xs2_ff, ys2_ff, zs2_ff;
   coef_type  c2_ff;

   // stage 3: matrix
   mat_type mat_ff, mat_in;

   always_comb begin
      axis_x_in = axis_x_ff;
      axis_y_in = axis_y_ff;
      axis_z_in = axis_z_ff;
      cos_in    = cos_ff;
      sin_in    = sin_ff;
      origin_in = origin_ff;
      if (wr_en) begin
         case (reg_index_type'(wr_index))
            REG_AXIS_X:   axis_x_in    = wr_data[COEF_WIDTH-1:0];
            REG_AXIS_Y:   axis_y_in    = wr_data[COEF_WIDTH-1:0];
            REG_AXIS_Z:   axis_z_in    = wr_data[COEF_WIDTH-1:0];
            REG_COS:      cos_in       = wr_data[COEF_WIDTH-1:0];
            REG_SIN:      sin_in       = wr_data[COEF_WIDTH-1:0];
            REG_ORIGIN_X: origin_in[0] = wr_data[COORD_WIDTH-1:0];
            REG_ORIGIN_Y: origin_in[1] = wr_data[COORD_WIDTH-1:0];
            REG_ORIGIN_Z: origin_in[2] = wr_data[COORD_WIDTH-1:0];
            default:      ;
         endcase
      end
      if (wr_en) begin
         settle_in = SETTLE_W'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff <= '0;
         axis_y_ff <= '0;
         axis_z_ff <= COEF_ONE;
         cos_ff    <= COEF_ONE;
         sin_ff    <= '0;
         origin_ff <= '0;
         settle_ff <= SETTLE_W'(SETTLE_CYCLES);
      end else begin
         axis_x_ff <= axis_x_in;
         axis_y_ff <= axis_y_in;
         axis_z_ff <= axis_z_in;
         cos_ff    <= cos_in;
         sin_ff    <= sin_in;
         origin_ff <= origin_in;
         settle_ff <= settle_in;
      end
   end

   always_comb begin
      xx_in  = coef_rnd_mul(axis_x_ff, axis_x_ff);
      yy_in  = coef_rnd_mul(axis_y_ff, axis_y_ff);
      zz_in  = coef_rnd_mul(axis_z_ff, axis_z_ff);
      xy_in  = coef_rnd_mul(axis_x_ff, axis_y_ff);
      xz_in  = coef_rnd_mul(axis_x_ff, axis_z_ff);
      yz_in  = coef_rnd_mul(axis_y_ff, axis_z_ff);
      xs1_in = coef_rnd_mul(axis_x_ff, sin_ff);
      ys1_in = coef_rnd_mul(axis_y_ff, sin_ff);
      zs1_in = coef_rnd_mul(axis_z_ff, sin_ff);
      omc_in = OMC_W'(COEF_ONE) - OMC_W'(cos_ff);
      c1_in  = cos_ff;

      kxx_in = k_rnd_mul(omc_ff, xx_ff);
      kyy_in = k_rnd_mul(omc_ff, yy_ff);
      kzz_in = k_rnd_mul(omc_ff, zz_ff);
      kxy_in = k_rnd_mul(omc_ff, xy_ff);
      kxz_in = k_rnd_mul(omc_ff, xz_ff);
      kyz_in = k_rnd_mul(omc_ff, yz_ff);

      mat_in[0] = MAT_W'(c2_ff)  + MAT_W'(kxx_ff);
      mat_in[1] = MAT_W'(kxy_ff) - MAT_W'(zs2_ff);
      mat_in[2] = MAT_W'(kxz_ff) + MAT_W'(ys2_ff);
      mat_in[3] = MAT_W'(kxy_ff) + MAT_W'(zs2_ff);
      mat_in[4] = MAT_W'(c2_ff)  + MAT_W'(kyy_ff);
      mat_in[5] = MAT_W'(kyz_ff) - MAT_W'(xs2_ff);
      mat_in[6] = MAT_W'(kxz_ff) - MAT_W'(ys2_ff);
      mat_in[7] = MAT_W'(kyz_ff) + MAT_W'(xs2_ff);
      mat_in[8] = MAT_W'(c2_ff)  + MAT_W'(kzz_ff);
   end

   // free-running; settle_ff holds off items until the matrix catches up
   always_ff @(posedge clock) begin
      xx_ff  <= xx_in;
      yy_ff  <= yy_in;
      zz_ff  <= zz_in;
      xy_ff  <= xy_in;
      xz_ff  <= xz_in;
      yz_ff  <= yz_in;
      xs1_ff <= xs1_in;
      ys1_ff <= ys1_in;
      zs1_ff <= zs1_in;
      omc_ff <= omc_in;
      c1_ff  <= c1_in;

      kxx_ff <= kxx_in;
      kyy_ff <= kyy_in;
      kzz_ff <= kzz_in;
      kxy_ff <= kxy_in;
      kxz_ff <= kxz_in;
      kyz_ff <= kyz_in;
      xs2_ff <= xs1_ff;
      ys2_ff <= ys1_ff;
      zs2_ff <= zs1_ff;
      c2_ff  <= c1_ff;

      mat_ff <= mat_in;
   end

   assign cfg.mat     = mat_ff;
   assign cfg.origin  = origin_ff;
   assign cfg.settled = (settle_ff == '0);

endmodule

// ===== hdl/aapr_datapath.sv =====
// Four-stage point pipeline: offset, matrix products, row sums, shift back and saturate.
module aapr_datapath
   import aapr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            in_valid,
   output logic            in_ready,
   input  coord_type [2:0] in_point,
   input  logic            in_last,
   output logic            out_valid,
   input  logic            out_ready,
   output coord_type [2:0] out_point,
   output logic            out_last
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic en1, en2, en3, en4;
   logic l1_ff, l2_ff, l3_ff, l4_ff;

   logic signed [D_W-1:0]    d_ff   [3];
   logic signed [D_W-1:0]    d_in   [3];
   logic signed [PROD_W-1:0] prod_ff [9];
   logic signed [PROD_W-1:0] prod_in [9];
   logic signed [ACC_W-1:0]  acc_ff [3];
   logic signed [ACC_W-1:0]  acc_in [3];
   coord_type [2:0]          res_ff, res_in;

   logic signed [SH_W-1:0]          sh   [3];
   logic signed [SUM_W-1:0]         sum  [3];
   logic [SUM_W-COORD_WIDTH:0]      hi   [3];

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // a stage takes new data when it is empty or its item moves on
   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1 && cfg.settled;

   always_comb begin
      v1_in = en1 ? (in_valid && in_ready) : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;
      v4_in = en4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         d_in[j] = D_W'(in_point[j]) - D_W'(cfg.origin[j]);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[3*i+j] = $signed(cfg.mat[3*i+j]) * d_ff[j];
         end
      end
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = ACC_W'(prod_ff[3*i]) + ACC_W'(prod_ff[3*i+1])
                   + ACC_W'(prod_ff[3*i+2]) + ACC_W'(HALF);
      end
      for (int i = 0; i < 3; i++) begin
         sh[i]  = SH_W'(acc_ff[i] >>> FRAC);
         sum[i] = SUM_W'(sh[i]) + SUM_W'(cfg.origin[i]);
         hi[i]  = sum[i][SUM_W-1:COORD_WIDTH-1];
         if ((&hi[i]) || !(|hi[i])) begin
            res_in[i] = sum[i][COORD_WIDTH-1:0];
         end else if (sum[i][SUM_W-1]) begin
            res_in[i] = COORD_MIN;
         end else begin
            res_in[i] = COORD_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         d_ff  <= d_in;
         l1_ff <= in_last;
      end
      if (en2) begin
         prod_ff <= prod_in;
         l2_ff   <= l1_ff;
      end
      if (en3) begin
         acc_ff <= acc_in;
         l3_ff  <= l2_ff;
      end
      if (en4) begin
         res_ff <= res_in;
         l4_ff  <= l3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_point = res_ff;
   assign out_last  = l4_ff;

endmodule

// ===== hdl/axis_angle_point_rotator_top.sv =====
// Top level of the axis-angle point rotator: stream ports, settings port, datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tdata: point_x, point_y, point_z; tlast: last_point
//   rsp      out        rsp_tvalid/tready    tdata: rotated_x, rotated_y, rotated_z; tlast: last_out
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One item per cycle while rsp is open and the matrix has settled; an accepted item passes
// the offset, product, row-sum and result registers before rsp_tvalid rises.
// The nine matrix-by-offset multipliers sit in one stage; the matrix itself is formed in a
// separate three-stage pipeline from the settings registers.
// After reset and after each settings write, req_tready stays low until the matrix has settled.
// Reset is synchronous, active high; a stall on rsp fills pipeline bubbles before it blocks req.
module axis_angle_point_rotator_top
   import aapr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_WIDTH-1:0] req_tdata,  // point_x, point_y, point_z
   input  logic                   req_tlast,  // last_point
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_WIDTH-1:0] rsp_tdata,  // rotated_x, rotated_y, rotated_z
   output logic                   rsp_tlast,  // last_out
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]   csr_data
);

   cfg_type         cfg;
   coord_type [2:0] in_point;
   coord_type [2:0] out_point;

   // a write never lands on the same edge as an item
   assign csr_ready = !(req_tvalid && req_tready);

   aapr_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         in_point[j] = req_tdata[j*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   aapr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_point  (in_point),
      .in_last   (req_tlast),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_point (out_point),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = TDATA_WIDTH'({out_point[2], out_point[1], out_point[0]});

endmodule

// ===== hdl/aapr_checker.sv =====
// Port-level checks for the axis-angle point rotator, bound to the top level.
module aapr_checker
   import aapr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [TDATA_WIDTH-1:0] rsp_tdata,
   input logic                   rsp_tlast,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // matrix must settle before the next item
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("item accepted right after settings write");

   assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready && csr_valid && csr_ready))
      else $error("item and settings write on the same edge");

   // with rsp open the accepted item reaches rsp_tvalid
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("item lost in an unstalled pipeline");

   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind axis_angle_point_rotator_top aapr_checker u_aapr_checker (.*);
